// ----- sv/ttd_pkg.sv -----
// ----------------------------------------------------------------------------
// ttd_pkg
// Shared types and constants of the tick task dispatcher.
// ----------------------------------------------------------------------------
package ttd_pkg;

	// table slots; entry_index and task_index are sized for this
	localparam int TASK_SLOTS = 64;

	localparam logic [1:0] OP_LOAD    = 2'd0;
	localparam logic [1:0] OP_START   = 2'd1;
	localparam logic [1:0] OP_FINISH  = 2'd2;
	localparam logic [1:0] OP_INVALID = 2'd3;

	localparam logic [1:0] KIND_LOADED = 2'd0;
	localparam logic [1:0] KIND_DISP   = 2'd1;
	localparam logic [1:0] KIND_LOOP   = 2'd2;
	localparam logic [1:0] KIND_REJECT = 2'd3;

	localparam logic [1:0] REG_PERIOD = 2'd0;
	localparam logic [1:0] REG_FAST   = 2'd1;
	localparam logic [1:0] REG_SLOW   = 2'd2;
	localparam logic [1:0] REG_TASKS  = 2'd3;

	localparam logic [12:0] EXTRA_MAX  = 13'd5000;
	localparam logic [12:0] EXTRA_UP   = 13'd100;
	localparam logic [12:0] EXTRA_DOWN = 13'd50;
	localparam logic [5:0]  CLEAN_MAX  = 6'd50;

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_RD    = 7'b0000010,
		ST_EVAL  = 7'b0000100,
		ST_MUL   = 7'b0001000,
		ST_CHK   = 7'b0010000,
		ST_WAIT  = 7'b0100000,
		ST_OUT   = 7'b1000000
	} state_t;

endpackage

// ----- sv/ttd_ram.sv -----
// ----------------------------------------------------------------------------
// ttd_ram
// Generic single-port-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ttd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule

// ----- sv/tick_task_dispatcher_unit.sv -----
// ----------------------------------------------------------------------------
// tick_task_dispatcher_unit
// Rate-monotonic tick scheduler: walks a task table each loop and hands out
// dispatches under a time budget that adapts to missed deadlines.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  in      | sink      | in_valid/in_stall  | operation, entry_*, elapsed_us, task_time_us
//  out     | source    | out_valid/out_stall| kind, task_index, allowed_us, flags, stats
//  cfg     | sink      | cfg_we             | cfg_index, cfg_data
//
//  A start or finish item steps through the table entry by entry (read,
//  compare, multiply, check); the shared multiplier and the one table read
//  port make the walk serial. Reset clears control and statistics;
//  last_run_tick is cleared by per-entry valid bits. in_stall is high from
//  acceptance until the result beat leaves the output register.
// ----------------------------------------------------------------------------
module tick_task_dispatcher_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  operation,
	input  logic [5:0]  entry_index,
	input  logic [7:0]  entry_priority,
	input  logic [15:0] entry_interval,
	input  logic [15:0] entry_budget_us,
	input  logic [31:0] elapsed_us,
	input  logic [31:0] task_time_us,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  kind,
	output logic [5:0]  task_index,
	output logic [15:0] allowed_us,
	output logic        slipped,
	output logic        overran,
	output logic [12:0] extra_budget_us,
	output logic [31:0] spare_sum_us,
	output logic [4:0]  spare_loops,
	output logic [6:0]  slip_count,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [14:0] cfg_data
);
	import ttd_pkg::*;

	localparam int AW = $clog2(TASK_SLOTS);
	localparam logic [6:0] NT7 = 7'(TASK_SLOTS);

	state_t state_q;

	logic [14:0] period_q;
	logic [7:0]  fast_q, slow_q;
	logic [6:0]  tasks_q;

	logic [15:0] tick_q;
	logic [6:0]  pos_q;
	logic        busy_q;
	logic [31:0] left_q;
	logic [15:0] cur_allowed_q;
	logic [12:0] extra_q;
	logic [5:0]  clean_q;
	logic [7:0]  miss_q;
	logic [31:0] spare_q;
	logic [4:0]  sloops_q;
	logic [6:0]  slips_q;
	logic        ovr_q;
	logic [TASK_SLOTS-1:0] lr_valid_q;

	logic [16:0] iv_q, dt_q;
	logic [23:0] prod_q;
	logic        slip_q;

	// table memories
	logic          we_tab, we_lr;
	logic [AW-1:0] waddr, lr_waddr, raddr;
	logic [7:0]    rd_pri;
	logic [15:0]   rd_iv, rd_bud, rd_lr;

	assign raddr = pos_q[AW-1:0];
	assign waddr = entry_index[AW-1:0];

	ttd_ram #(.WIDTH(8),  .DEPTH(TASK_SLOTS)) u_pri (.clk, .we(we_tab), .waddr,
		.wdata(entry_priority), .raddr, .rdata(rd_pri));
	ttd_ram #(.WIDTH(16), .DEPTH(TASK_SLOTS)) u_iv (.clk, .we(we_tab), .waddr,
		.wdata(entry_interval), .raddr, .rdata(rd_iv));
	ttd_ram #(.WIDTH(16), .DEPTH(TASK_SLOTS)) u_bud (.clk, .we(we_tab), .waddr,
		.wdata(entry_budget_us), .raddr, .rdata(rd_bud));
	ttd_ram #(.WIDTH(16), .DEPTH(TASK_SLOTS)) u_lr (.clk, .we(we_lr), .waddr(lr_waddr),
		.wdata(tick_q), .raddr, .rdata(rd_lr));

	logic acc_in, acc_out;
	assign in_stall = (state_q != ST_IDLE) || out_valid;
	assign acc_in   = in_valid && !in_stall;
	assign acc_out  = out_valid && !out_stall;

	logic [6:0] limit;
	assign limit = (tasks_q > NT7) ? NT7 : tasks_q;

	logic idx_ok;
	assign idx_ok = ({1'b0, entry_index} < NT7);

	assign we_tab = acc_in && operation == OP_LOAD && !busy_q && idx_ok;
	assign we_lr  = acc_in && operation == OP_FINISH && busy_q && pos_q < NT7;
	assign lr_waddr = pos_q[AW-1:0];

	logic [15:0] lr_eff;
	assign lr_eff = lr_valid_q[raddr] ? rd_lr : 16'd0;

	// end-of-loop statistics
	logic [32:0] ssum;
	logic [31:0] ssat;
	logic [4:0]  nloops;
	assign ssum   = {1'b0, spare_q} + {1'b0, left_q};
	assign ssat   = ssum[32] ? 32'hFFFF_FFFF : ssum[31:0];
	assign nloops = sloops_q + 5'd1;

	logic [12:0] ext_up;
	assign ext_up = (extra_q + EXTRA_UP > EXTRA_MAX) ? EXTRA_MAX : extra_q + EXTRA_UP;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= 15'd2500;
			fast_q   <= 8'd3;
			slow_q   <= 8'd4;
			tasks_q  <= 7'd0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PERIOD: period_q <= cfg_data;
				REG_FAST:   fast_q   <= cfg_data[7:0];
				REG_SLOW:   slow_q   <= cfg_data[7:0];
				REG_TASKS:  tasks_q  <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid <= 1'b0;
			tick_q <= '0; pos_q <= '0; busy_q <= 1'b0; left_q <= '0;
			cur_allowed_q <= '0; extra_q <= '0; clean_q <= '0; miss_q <= '0;
			spare_q <= '0; sloops_q <= '0; slips_q <= '0; ovr_q <= 1'b0;
			lr_valid_q <= '0;
			kind <= '0; task_index <= '0; allowed_us <= '0; slipped <= 1'b0;
			overran <= 1'b0;
			iv_q <= '0; dt_q <= '0; prod_q <= '0; slip_q <= 1'b0;
		end else begin
			if (acc_out)
				out_valid <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (acc_in) begin
						if (we_tab) begin
							kind <= KIND_LOADED; task_index <= entry_index;
							allowed_us <= '0; slipped <= 1'b0; overran <= 1'b0;
							state_q <= ST_OUT;
						end else if (operation == OP_START && !busy_q) begin
							tick_q <= tick_q + 16'd1;
							left_q <= ((elapsed_us < {17'd0, period_q}) ?
								{17'd0, period_q} - elapsed_us : 32'd0) +
								{19'd0, extra_q};
							pos_q <= '0; slips_q <= '0; busy_q <= 1'b1;
							ovr_q <= 1'b0;
							state_q <= ST_RD;
						end else if (operation == OP_FINISH && busy_q) begin
							ovr_q <= task_time_us > {16'd0, cur_allowed_q};
							if (pos_q < NT7)
								lr_valid_q[pos_q[AW-1:0]] <= 1'b1;
							left_q <= (task_time_us >= left_q) ? 32'd0 :
								left_q - task_time_us;
							pos_q <= pos_q + 7'd1;
							state_q <= ST_RD;
						end else begin
							kind <= KIND_REJECT; task_index <= '0; allowed_us <= '0;
							slipped <= 1'b0; overran <= 1'b0;
							state_q <= ST_OUT;
						end
					end
				end
				ST_RD: begin
					// ram address is pos_q; data valid next cycle
					if (pos_q < limit)
						state_q <= ST_EVAL;
					else begin
						// count wraps to zero at 32 loops: halve sum and count
						spare_q  <= (nloops == 5'd0) ? ssat >> 1 : ssat;
						sloops_q <= (nloops == 5'd0) ? 5'd16 : nloops;
						if (miss_q != 8'd0) begin
							extra_q <= ext_up; miss_q <= '0; clean_q <= '0;
						end else if (extra_q != 13'd0) begin
							if (clean_q + 6'd1 > CLEAN_MAX) begin
								clean_q <= '0;
								extra_q <= (extra_q > EXTRA_DOWN) ? extra_q - EXTRA_DOWN : 13'd0;
							end else
								clean_q <= clean_q + 6'd1;
						end
						busy_q <= 1'b0; pos_q <= '0;
						kind <= KIND_LOOP; task_index <= '0; allowed_us <= '0;
						slipped <= 1'b0; overran <= ovr_q;
						state_q <= ST_OUT;
					end
				end
				ST_EVAL: begin
					if (rd_pri <= fast_q) begin
						cur_allowed_q <= {1'b0, period_q};
						kind <= KIND_DISP; task_index <= raddr;
						allowed_us <= {1'b0, period_q}; slipped <= 1'b0;
						overran <= ovr_q;
						state_q <= ST_OUT;
					end else begin
						iv_q <= (rd_iv == 16'd0) ? 17'd1 : {1'b0, rd_iv};
						dt_q <= {1'b0, tick_q - lr_eff};
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					if (dt_q < iv_q) begin
						pos_q <= pos_q + 7'd1;
						state_q <= ST_RD;
					end else begin
						slip_q <= dt_q >= {iv_q[15:0], 1'b0};
						if (dt_q >= {iv_q[15:0], 1'b0} && slips_q != 7'd127)
							slips_q <= slips_q + 7'd1;
						prod_q <= iv_q[15:0] * slow_q;
						state_q <= ST_CHK;
					end
				end
				ST_CHK: begin
					if ({7'd0, dt_q} >= prod_q && miss_q != 8'd255)
						miss_q <= miss_q + 8'd1;
					if ({16'd0, rd_bud} > left_q) begin
						pos_q <= pos_q + 7'd1;
						state_q <= ST_RD;
					end else begin
						cur_allowed_q <= rd_bud;
						kind <= KIND_DISP; task_index <= raddr;
						allowed_us <= rd_bud; slipped <= slip_q; overran <= ovr_q;
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					out_valid <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign extra_budget_us = extra_q;
	assign spare_sum_us    = spare_q;
	assign spare_loops     = sloops_q;
	assign slip_count      = slips_q;
endmodule

// ----- bench/ttd_checker.sv -----
// ----------------------------------------------------------------------------
// ttd_checker
// Watches the item, result and register ports of the tick task dispatcher,
// predicts every result beat from its own copy of the table and counters, and
// compares each result beat field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module ttd_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [1:0]  operation,
	input  logic [5:0]  entry_index,
	input  logic [7:0]  entry_priority,
	input  logic [15:0] entry_interval,
	input  logic [15:0] entry_budget_us,
	input  logic [31:0] elapsed_us,
	input  logic [31:0] task_time_us,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [1:0]  kind,
	input  logic [5:0]  task_index,
	input  logic [15:0] allowed_us,
	input  logic        slipped,
	input  logic        overran,
	input  logic [12:0] extra_budget_us,
	input  logic [31:0] spare_sum_us,
	input  logic [4:0]  spare_loops,
	input  logic [6:0]  slip_count,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [14:0] cfg_data,
	output int          fail_count,
	output int          pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import ttd_pkg::*;

	typedef struct packed {
		logic [1:0]  kind;
		logic [5:0]  idx;
		logic [15:0] allowed;
		logic        slipped;
		logic        overran;
		logic [12:0] extra;
		logic [31:0] spare;
		logic [4:0]  loops;
		logic [6:0]  slips;
	} dispatch_beat_t;

	dispatch_beat_t expected_beats[$];

	logic [7:0]  tbl_prio[TASK_SLOTS];
	logic [15:0] tbl_interval[TASK_SLOTS];
	logic [15:0] tbl_budget[TASK_SLOTS];
	logic [15:0] tbl_last_tick[TASK_SLOTS];
	logic [15:0] ticks;
	int unsigned pos;
	bit          busy;
	logic [31:0] time_left;
	logic [15:0] granted;
	logic [12:0] extra;
	int unsigned clean;
	int unsigned misses;
	logic [31:0] spare_acc;
	logic [4:0]  spare_n;
	logic [6:0]  slips;

	logic [14:0] r_period;
	logic [7:0]  r_fast;
	logic [7:0]  r_slow;
	logic [6:0]  r_tasks;

	function automatic dispatch_beat_t make_beat(logic [1:0] k, logic [5:0] i,
			logic [15:0] a, logic s, logic o);
		dispatch_beat_t b;
		b.kind    = k;
		b.idx     = i;
		b.allowed = a;
		b.slipped = s;
		b.overran = o;
		b.extra   = extra;
		b.spare   = spare_acc;
		b.loops   = spare_n;
		b.slips   = slips;
		return b;
	endfunction

	// resume the table walk from pos; returns a dispatch or the loop-end beat
	task automatic walk_table(input logic o, output dispatch_beat_t b);
		int unsigned limit;
		int unsigned dt;
		int unsigned iv;
		int unsigned allow;
		logic        sl;
		logic [63:0] s;
		int unsigned n;
		limit = (r_tasks > TASK_SLOTS) ? TASK_SLOTS : r_tasks;
		while (pos < limit) begin
			sl = 1'b0;
			if (tbl_prio[pos] > r_fast) begin
				dt = 16'(ticks - tbl_last_tick[pos]);
				iv = (tbl_interval[pos] == 0) ? 1 : tbl_interval[pos];
				if (dt < iv) begin
					pos++;
					continue;
				end
				allow = tbl_budget[pos];
				if (dt >= iv * 2) begin
					sl = 1'b1;
					if (slips < 127) slips++;
				end
				if (dt >= iv * r_slow && misses < 255) misses++;
				if (allow > time_left) begin
					pos++;
					continue;
				end
			end else begin
				allow = r_period;
			end
			granted = 16'(allow);
			b = make_beat(KIND_DISP, 6'(pos), granted, sl, o);
			return;
		end
		s = 64'(spare_acc) + 64'(time_left);
		n = spare_n + 1;
		if (s > 64'hFFFF_FFFF) s = 64'hFFFF_FFFF;
		if (n == 32) begin
			n = n / 2;
			s = s / 2;
		end
		spare_acc = 32'(s);
		spare_n = 5'(n);
		if (misses > 0) begin
			extra = (extra + EXTRA_UP > EXTRA_MAX) ? EXTRA_MAX : extra + EXTRA_UP;
			misses = 0;
			clean = 0;
		end else if (extra > 0) begin
			clean++;
			if (clean > CLEAN_MAX) begin
				clean = 0;
				extra = (extra > EXTRA_DOWN) ? extra - EXTRA_DOWN : '0;
			end
		end
		busy = 1'b0;
		pos = 0;
		b = make_beat(KIND_LOOP, '0, '0, 1'b0, o);
	endtask

	task automatic predict_beat(output dispatch_beat_t b);
		logic o;
		if (operation == OP_LOAD) begin
			if (busy) begin
				b = make_beat(KIND_REJECT, '0, '0, 1'b0, 1'b0);
			end else begin
				tbl_prio[entry_index]     = entry_priority;
				tbl_interval[entry_index] = entry_interval;
				tbl_budget[entry_index]   = entry_budget_us;
				b = make_beat(KIND_LOADED, entry_index, '0, 1'b0, 1'b0);
			end
		end else if (operation == OP_START) begin
			if (busy) begin
				b = make_beat(KIND_REJECT, '0, '0, 1'b0, 1'b0);
			end else begin
				ticks++;
				time_left = ((elapsed_us < r_period) ? r_period - elapsed_us : 32'd0) + extra;
				pos = 0;
				slips = '0;
				busy = 1'b1;
				walk_table(1'b0, b);
			end
		end else if (operation == OP_FINISH && busy) begin
			o = task_time_us > granted;
			if (pos < TASK_SLOTS) tbl_last_tick[pos] = ticks;
			time_left = (task_time_us >= time_left) ? 32'd0 : time_left - task_time_us;
			pos++;
			walk_table(o, b);
		end else begin
			b = make_beat(KIND_REJECT, '0, '0, 1'b0, 1'b0);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		dispatch_beat_t b;
		dispatch_beat_t got;
		if (!arst_n) begin
			for (int i = 0; i < TASK_SLOTS; i++) tbl_last_tick[i] = '0;
			ticks = '0;
			pos = 0;
			busy = 1'b0;
			time_left = '0;
			granted = '0;
			extra = '0;
			clean = 0;
			misses = 0;
			spare_acc = '0;
			spare_n = '0;
			slips = '0;
			r_period = 15'd2500;
			r_fast = 8'd3;
			r_slow = 8'd4;
			r_tasks = 7'd0;
			expected_beats.delete();
			fail_count <= 0;
			pending <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_PERIOD: r_period = cfg_data;
					REG_FAST:   r_fast = cfg_data[7:0];
					REG_SLOW:   r_slow = cfg_data[7:0];
					REG_TASKS:  r_tasks = cfg_data[6:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				predict_beat(b);
				expected_beats.push_back(b);
			end
			if (out_valid && !out_stall) begin
				got = '{kind, task_index, allowed_us, slipped, overran, extra_budget_us,
					spare_sum_us, spare_loops, slip_count};
				if (expected_beats.size() == 0) begin
					if (fail_count < 10)
						$display("%0t: result beat with nothing expected: %p", $realtime, got);
					fail_count <= fail_count + 1;
				end else begin
					b = expected_beats.pop_front();
					if (got.kind !== b.kind || got.idx !== b.idx || got.allowed !== b.allowed
							|| got.slipped !== b.slipped || got.overran !== b.overran
							|| got.extra !== b.extra || got.spare !== b.spare
							|| got.loops !== b.loops || got.slips !== b.slips) begin
						if (fail_count < 10)
							$display("%0t: mismatch\n  expected %p\n  actual   %p",
								$realtime, b, got);
						fail_count <= fail_count + 1;
					end
				end
			end
			pending <= expected_beats.size();
		end
	end

endmodule

// ----- bench/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Drives the tick task dispatcher with table loads and scheduler loops that
// answer every dispatch with a finish, plus noise items (rejected inside a loop), under random
// gaps and back-pressure; the checker beside the block judges each beat.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import ttd_pkg::*;

	localparam int CYCLE_LIMIT = 3000000;
	localparam int RANDOM_ITEMS = 1700;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  operation;
	logic [5:0]  entry_index;
	logic [7:0]  entry_priority;
	logic [15:0] entry_interval;
	logic [15:0] entry_budget_us;
	logic [31:0] elapsed_us;
	logic [31:0] task_time_us;
	logic        out_valid;
	logic        out_stall;
	logic [1:0]  kind;
	logic [5:0]  task_index;
	logic [15:0] allowed_us;
	logic        slipped;
	logic        overran;
	logic [12:0] extra_budget_us;
	logic [31:0] spare_sum_us;
	logic [4:0]  spare_loops;
	logic [6:0]  slip_count;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [14:0] cfg_data;

	int          fail_count;
	int          pending;
	int          cycles;
	int          beats;
	int          items_sent;
	logic [1:0]  last_kind;
	logic [14:0] cur_period;

	tick_task_dispatcher_unit u_top (.*);
	ttd_checker u_chk (.*);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("[tick_task_dispatcher_unit] ERROR");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (out_valid && !out_stall) begin
			beats <= beats + 1;
			last_kind <= kind;
		end
	end

	// receiver back-pressure, quiet for a long stretch mid-run
	always @(negedge clk) begin
		if (items_sent >= 600 && items_sent < 900) out_stall <= 1'b0;
		else out_stall <= ($urandom_range(99) < 34);
	end

	task automatic send_beat(input logic [1:0] op, input logic [5:0] idx,
			input logic [7:0] prio, input logic [15:0] iv, input logic [15:0] bud,
			input logic [31:0] el, input logic [31:0] tt);
		int n;
		while (!(items_sent >= 600 && items_sent < 900) && $urandom_range(99) < 34)
			@(negedge clk);
		@(negedge clk);
		in_valid <= 1'b1;
		operation <= op;
		entry_index <= idx;
		entry_priority <= prio;
		entry_interval <= iv;
		entry_budget_us <= bud;
		elapsed_us <= el;
		task_time_us <= tt;
		do @(posedge clk); while (in_stall);
		n = beats;
		items_sent++;
		@(negedge clk);
		in_valid <= 1'b0;
		while (beats == n) @(posedge clk);
		@(posedge clk);
	endtask

	task automatic write_regs(input logic [14:0] period, input logic [7:0] fast,
			input logic [7:0] slow, input logic [6:0] ntasks);
		repeat (20) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= REG_PERIOD;
		cfg_data <= period;
		@(negedge clk);
		cfg_index <= REG_FAST;
		cfg_data <= {7'($urandom), fast};
		@(negedge clk);
		cfg_index <= REG_SLOW;
		cfg_data <= {7'($urandom), slow};
		@(negedge clk);
		cfg_index <= REG_TASKS;
		cfg_data <= {8'($urandom), ntasks};
		@(negedge clk);
		cfg_we <= 1'b0;
		cur_period = period;
	endtask

	function automatic logic [31:0] pick_time(int unsigned scale);
		int unsigned r;
		r = $urandom_range(99);
		if (r < 70) return $urandom_range(0, scale);
		if (r < 90) return $urandom_range(0, 10 * scale + 1000);
		return $urandom;
	endfunction

	task automatic load_entry(input logic [5:0] idx, input logic [7:0] prio,
			input logic [15:0] iv, input logic [15:0] bud);
		send_beat(OP_LOAD, idx, prio, iv, bud, $urandom, $urandom);
	endtask

	task automatic noise_beat();
		case ($urandom_range(2))
			0: load_entry(6'($urandom), 8'($urandom), 16'($urandom), 16'($urandom));
			1: send_beat(OP_START, 6'($urandom), 8'($urandom), 16'($urandom),
				16'($urandom), $urandom, $urandom);
			default: send_beat(OP_INVALID, 6'($urandom), 8'($urandom), 16'($urandom),
				16'($urandom), $urandom, $urandom);
		endcase
	endtask

	// one scheduler loop: start, then finish each dispatched task
	task automatic run_loop(input logic [31:0] el, input int noise_pct);
		logic [1:0] k;
		send_beat(OP_START, 6'($urandom), 8'($urandom), 16'($urandom),
			16'($urandom), el, $urandom);
		k = last_kind;
		while (k == KIND_DISP) begin
			if ($urandom_range(99) < noise_pct) noise_beat();
			send_beat(OP_FINISH, 6'($urandom), 8'($urandom), 16'($urandom),
				16'($urandom), $urandom, pick_time(cur_period));
			k = last_kind;
		end
	endtask

	initial begin
		int loops;
		arst_n = 1'b0;
		in_valid = 1'b0;
		operation = OP_LOAD;
		entry_index = '0;
		entry_priority = '0;
		entry_interval = '0;
		entry_budget_us = '0;
		elapsed_us = '0;
		task_time_us = '0;
		out_stall = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_PERIOD;
		cfg_data = '0;
		cycles = 0;
		beats = 0;
		items_sent = 0;
		last_kind = KIND_LOADED;
		cur_period = 15'd2500;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// an idle block answers loops with no table, and rejects stray finishes
		run_loop(32'd0, 0);
		send_beat(OP_FINISH, '0, '0, '0, '0, '0, 32'hFFFF_FFFF);
		send_beat(OP_INVALID, 6'h3F, 8'hFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF,
			32'hFFFF_FFFF);

		// fill the whole table first so no walk reads an unwritten slot
		load_entry(6'd0, 8'd0, 16'd0, 16'd0);
		for (int i = 1; i < 63; i++)
			load_entry(6'(i), 8'($urandom), 16'($urandom_range(0, 6)),
				16'($urandom_range(0, 3000)));
		load_entry(6'd63, 8'hFF, 16'hFFFF, 16'hFFFF);

		write_regs(15'd500, 8'd0, 8'd1, 7'd64);
		run_loop(32'd0, 100);
		run_loop(32'hFFFF_FFFF, 50);
		run_loop(32'd100, 0);
		write_regs(15'd20000, 8'd255, 8'd255, 7'd127);
		run_loop(32'd0, 30);
		write_regs(15'd2500, 8'd3, 8'd4, 7'd100);
		run_loop(32'd1000, 0);
		write_regs(15'd2500, 8'd3, 8'd4, 7'd0);
		run_loop(32'd0, 0);

		items_sent = 0;
		loops = 0;
		while (items_sent < RANDOM_ITEMS) begin
			if (loops % 12 == 0)
				write_regs(
					($urandom_range(9) == 0) ? 15'd20000 :
					($urandom_range(9) == 0) ? 15'd500 : 15'($urandom_range(500, 5000)),
					($urandom_range(2) == 0) ? 8'($urandom_range(0, 10)) : 8'($urandom),
					($urandom_range(3) == 0) ? 8'($urandom_range(1, 255))
						: 8'($urandom_range(1, 8)),
					($urandom_range(9) == 0) ? 7'($urandom_range(65, 127))
						: 7'($urandom_range(0, 64)));
			if ($urandom_range(99) < 30)
				load_entry(6'($urandom), 8'($urandom),
					($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 10)),
					($urandom_range(9) == 0) ? 16'($urandom)
						: 16'($urandom_range(0, cur_period)));
			if ($urandom_range(99) < 5) begin
				noise_beat();
				// a stray start on an idle block opens a loop: close it
				while (last_kind == KIND_DISP)
					send_beat(OP_FINISH, 6'($urandom), 8'($urandom), 16'($urandom),
						16'($urandom), $urandom, pick_time(cur_period));
			end
			run_loop(pick_time(cur_period), 8);
			loops++;
		end

		while (pending != 0) @(posedge clk);
		repeat (300) @(posedge clk);
		if (fail_count == 0) begin
			$display("[tick_task_dispatcher_unit] OK");
		end else begin
			$display("[tick_task_dispatcher_unit] ERROR");
		end
		$finish;
	end

endmodule
